// ===== rtl/core/pwfs_pkg.sv =====
// pwfs_pkg: shared constants and types for the parabolic window fir smoother
// no dependencies; used by pwfs_mac and parabolic_window_fir_smoother
`default_nettype none

package pwfs_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int WIN_FIELD_W  = 7;
  localparam int WINDOW_RESET = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL = 2'd1;

  // commands from the sequencer to the mac unit
  typedef struct packed {
    logic load;    // request accepted: write sample and run one pass
    logic refill;  // history back to initial level, write position to zero
  } mac_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/parabolic_window_fir_smoother.sv =====
// parabolic_window_fir_smoother: top level, config registers and sequencer
// depends on pwfs_pkg, pwfs_mac, pwfs_div
//
//   channel  dir  ports                           request taken when
//   in       in   in_valid in_stall in_sample     in_valid & !in_stall
//   out      out  out_valid out_stall out_smoothed out_valid & !out_stall
//   cfg      in   cfg_we cfg_idx cfg_data         cfg_we
//
// a request runs a mac pass and then a divide before its result reaches the output
// register, and the next request is taken once the sequencer is back in idle
// reset is synchronous; unwritten history entries read as the initial level
// through per-entry valid bits, so no clearing pass is run
// in_stall is high from acceptance until the result is in the output register;
// a held result in the output register does not stop the next request
`default_nettype none

module parabolic_window_fir_smoother #(
  parameter int MAX_WINDOW  = pwfs_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = pwfs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]      in_sample,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed      [SAMPLE_BITS-1:0]      out_smoothed,
  input  wire logic                               cfg_we,
  input  wire logic        [pwfs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic        [pwfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pwfs_pkg::*;

  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int DEN_MAX = MAX_WINDOW * (MAX_WINDOW + 1) * (MAX_WINDOW + 2) / 6;
  localparam int DEN_W   = $clog2(DEN_MAX + 1);
  localparam int ACC_W   = DEN_W + SAMPLE_BITS;
  localparam int WIN_RST = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_DIV, S_HOLD} state_t;

  state_t                         state_r, state_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0]  out_smoothed_r, out_smoothed_nxt;

  logic        [CNT_W-1:0]        win_r, win_nxt;
  logic signed [SAMPLE_BITS-1:0]  init_r, init_nxt;
  logic                           refill;
  logic        [WIN_FIELD_W-1:0]  win_fld;
  logic [SAMPLE_BITS+CFG_DATA_W-1:0] lvl_ext;

  mac_cmd_t                       mac_cmd;
  logic                           mac_done;
  logic signed [ACC_W-1:0]        mac_acc;
  logic        [DEN_W-1:0]        mac_den;
  logic                           div_done;
  logic signed [SAMPLE_BITS-1:0]  div_quo;

  logic                           in_acc, out_free, res_ld;

  // configuration decode
  always_comb begin
    win_fld  = cfg_data[WIN_FIELD_W-1:0];
    lvl_ext  = {{SAMPLE_BITS{1'b0}}, cfg_data};
    win_nxt  = win_r;
    init_nxt = init_r;
    refill   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_WINDOW_LENGTH: begin
          if (win_fld == '0) begin
            win_nxt = CNT_W'(1);
          end else if (int'(win_fld) > MAX_WINDOW) begin
            win_nxt = CNT_W'(MAX_WINDOW);
          end else begin
            win_nxt = CNT_W'(win_fld);
          end
          refill = 1'b1;
        end
        REG_INITIAL_LEVEL: begin
          init_nxt = $signed(lvl_ext[SAMPLE_BITS-1:0]);
          refill   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= CNT_W'(WIN_RST);
      init_r <= '0;
    end else begin
      win_r  <= win_nxt;
      init_r <= init_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign res_ld   = ((state_r == S_DIV) && div_done && out_free) ||
                    ((state_r == S_HOLD) && out_free);

  assign mac_cmd.load   = in_acc;
  assign mac_cmd.refill = refill;

  pwfs_mac #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .DEN_W       (DEN_W),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (mac_cmd),
    .sample   (in_sample),
    .win      (win_r),
    .init_lvl (init_r),
    .done     (mac_done),
    .acc      (mac_acc),
    .den      (mac_den)
  );

  pwfs_div #(
    .NUM_W (ACC_W),
    .DEN_W (DEN_W),
    .Q_W   (SAMPLE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_done),
    .num   (mac_acc),
    .den   (mac_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r;
    out_smoothed_nxt = out_smoothed_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_MAC;
      S_MAC:  if (mac_done) state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = out_free ? S_IDLE : S_HOLD;
      S_HOLD: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (res_ld) begin
      out_valid_nxt    = 1'b1;
      out_smoothed_nxt = div_quo;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_smoothed_r <= out_smoothed_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_smoothed = out_smoothed_r;

  a_mac_done_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == S_MAC)
    else $error("mac pass finished outside its state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside its state");

  a_request_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_MAC)
    else $error("accepted request did not start a mac pass");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_ld |-> !(out_valid_r && out_stall))
    else $error("result loaded over a held output");

endmodule

`default_nettype wire

// ===== rtl/core/pwfs_mac.sv =====
// pwfs_mac: sample history memory and the shared multiply-accumulate pass
// depends on pwfs_pkg (mac_cmd_t)
`default_nettype none

module pwfs_mac #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 7,
  parameter int DEN_W       = 16,
  parameter int ACC_W       = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pwfs_pkg::mac_cmd_t            cmd,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic        [CNT_W-1:0]       win,
  input  wire logic signed [SAMPLE_BITS-1:0] init_lvl,
  output logic                               done,
  output logic signed      [ACC_W-1:0]       acc,
  output logic             [DEN_W-1:0]       den
);
  import pwfs_pkg::*;

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WW = 2 * CNT_W;
  localparam int PW = WW + 1 + SAMPLE_BITS;

  logic        [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic        [MAX_WINDOW-1:0]  valid_r;
  logic        [AW-1:0]          wp_r;

  logic                          issue_r;
  logic        [CNT_W-1:0]       h_r;
  logic        [AW-1:0]          k_r;

  logic                          s1_v_r, s2_v_r, s3_v_r, done_r;
  logic        [SAMPLE_BITS-1:0] rd_data_r;
  logic                          rd_ok_r;
  logic        [CNT_W-1:0]       kp1_r, nmk_r;
  logic        [WW-1:0]          weight_r;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic signed [PW-1:0]          prod_r;
  logic        [DEN_W-1:0]       den_r;
  logic signed [ACC_W-1:0]       acc_r;

  logic        [AW-1:0]          wp_eff;
  logic        [CNT_W-1:0]       wp_inc;
  logic        [AW-1:0]          wp_nxt;
  logic        [CNT_W-1:0]       k_start;
  logic        [CNT_W-1:0]       k_inc;
  logic        [CNT_W-1:0]       h_inc;

  always_comb begin
    wp_eff  = (CNT_W'(wp_r) >= win) ? '0 : wp_r;
    wp_inc  = CNT_W'(wp_eff) + CNT_W'(1);
    wp_nxt  = (wp_inc == win) ? '0 : wp_inc[AW-1:0];
    // window position of the entry at address zero, counted from the oldest entry
    k_start = win - CNT_W'(wp_eff) - CNT_W'(1);
    k_inc   = CNT_W'(k_r) + CNT_W'(1);
    h_inc   = h_r + CNT_W'(1);
  end

  // history memory, one write per request, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wp_eff] <= sample;
    end
    rd_data_r <= mem[h_r[AW-1:0]];
  end

  // control: valid bits, write position, sweep and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      wp_r    <= '0;
      issue_r <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      if (cmd.refill) begin
        valid_r <= '0;
        wp_r    <= '0;
      end else if (cmd.load) begin
        valid_r[wp_eff] <= 1'b1;
        wp_r            <= wp_nxt;
      end
      if (cmd.load) begin
        issue_r <= 1'b1;
      end else if (issue_r && h_inc == win) begin
        issue_r <= 1'b0;
      end
      s1_v_r <= issue_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      done_r <= s3_v_r && !s2_v_r && !s1_v_r && !issue_r;
    end
  end

  // datapath: address/window position, weight multiply, sample multiply, accumulate
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h_r   <= '0;
      k_r   <= k_start[AW-1:0];
      den_r <= '0;
      acc_r <= '0;
    end else begin
      if (issue_r) begin
        h_r     <= h_inc;
        k_r     <= (k_inc == win) ? '0 : k_inc[AW-1:0];
        kp1_r   <= k_inc;
        nmk_r   <= win - CNT_W'(k_r);
        rd_ok_r <= valid_r[h_r[AW-1:0]];
      end
      if (s1_v_r) begin
        weight_r <= WW'(kp1_r) * WW'(nmk_r);
        // an entry not written since refill or reset reads as the initial level
        samp_r   <= rd_ok_r ? $signed(rd_data_r) : init_lvl;
      end
      if (s2_v_r) begin
        prod_r <= PW'($signed({1'b0, weight_r})) * PW'(samp_r);
        den_r  <= den_r + DEN_W'(weight_r);
      end
      if (s3_v_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;
  assign den  = den_r;

endmodule

`default_nettype wire

// ===== rtl/core/pwfs_div.sv =====
// pwfs_div: signed by unsigned restoring divider, one quotient bit per cycle
// truncates toward zero; no package dependencies
`default_nettype none

module pwfs_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int Q_W   = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic        [DEN_W-1:0] den,
  output logic                         done,
  output logic signed      [Q_W-1:0]   quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic                   busy_r, fin_r, done_r, neg_r;
  logic [CW-1:0]          cnt_r;
  logic [DEN_W-1:0]       rem_r, den_r;
  logic [NUM_W-1:0]       sh_r;
  logic signed [Q_W-1:0]  quo_r;

  logic [DEN_W:0]         trial;
  logic                   take;

  always_comb begin
    trial = {rem_r, sh_r[NUM_W-1]};
    take  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      fin_r  <= busy_r && (cnt_r == CW'(1));
      done_r <= fin_r;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUM_W-1];
      // magnitude; the most negative value maps to its unsigned pattern
      sh_r  <= num[NUM_W-1] ? (~num + 1'b1) : num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= CW'(NUM_W);
    end else if (busy_r) begin
      rem_r <= take ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      sh_r  <= {sh_r[NUM_W-2:0], take};
      cnt_r <= cnt_r - CW'(1);
    end
    if (fin_r) begin
      quo_r <= neg_r ? Q_W'(~sh_r + 1'b1) : Q_W'(sh_r);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire
